// ----- src/pcr_pkg.sv -----
package pcr_pkg;

    localparam int VecW  = 48;
    localparam int CompW = 16;
    localparam int QuoW  = 43;
    localparam int RemW  = 17;
    localparam int DvdW  = QuoW + CompW;
    localparam int Lanes = 4;
    localparam int DivSteps = QuoW;

    localparam logic [1:0] LaneVelA  = 2'd0;
    localparam logic [1:0] LaneVelB  = 2'd1;
    localparam logic [1:0] LaneMoveA = 2'd2;
    localparam logic [1:0] LaneMoveB = 2'd3;

    localparam logic CfgRestitution = 1'b0;
    localparam logic CfgTimeStep    = 1'b1;

    typedef struct packed {
        logic [47:0] velocity_a;
        logic [47:0] velocity_b;
        logic [47:0] accel_a;
        logic [47:0] accel_b;
        logic [15:0] inv_mass_a;
        logic [15:0] inv_mass_b;
        logic        has_second;
        logic [47:0] contact_normal;
        logic signed [15:0] penetration;
    } t_in_item;

    typedef struct packed {
        logic [47:0] new_velocity_a;
        logic [47:0] new_velocity_b;
        logic [47:0] move_a;
        logic [47:0] move_b;
    } t_out_item;

    typedef struct packed {
        logic [VecW-1:0] velocity_a;
        logic [VecW-1:0] velocity_b;
        logic [VecW-1:0] normal;
        logic            two;
        logic            pass_vel;
        logic            zero_move;
    } t_side;

    typedef struct packed {
        logic [RemW-1:0] rem;
        logic [QuoW-1:0] work;
    } t_div_lane;

    typedef struct packed {
        t_div_lane [Lanes-1:0] lane;
        logic [RemW-1:0]       total;
        t_side                 side;
    } t_div_bus;

    function automatic logic signed [CompW-1:0] comp16(input logic [VecW-1:0] v,
                                                     input logic [1:0] i);
        logic signed [CompW-1:0] c;
        case (i)
            2'd0:    c = v[15:0];
            2'd1:    c = v[31:16];
            default: c = v[47:32];
        endcase
        return c;
    endfunction

    function automatic logic [CompW-1:0] sat16(input logic signed [44:0] x);
        logic [CompW-1:0] y;
        if (x > 45'sd32767) begin
            y = 16'h7fff;
        end else if (x < -45'sd32768) begin
            y = 16'h8000;
        end else begin
            y = x[15:0];
        end
        return y;
    endfunction

endpackage

// ----- src/pcr_front.sv -----
module pcr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  pcr_pkg::t_in_item i_data,
    input  logic [8:0]        i_restitution,
    input  logic [15:0]       i_time_step,
    output logic              o_valid,
    output pcr_pkg::t_div_bus o_bus
);

    typedef struct packed {
        logic [47:0]        velocity_a;
        logic [47:0]        velocity_b;
        logic [47:0]        normal;
        logic               two;
        logic [15:0]        ima;
        logic [15:0]        imb;
        logic [16:0]        total;
        logic signed [15:0] pen;
    } t_fsd;

    logic [4:0] r_v;
    t_fsd r_s1, r_s2, r_s3, r_s4, r_s5;

    logic signed [32:0] r_pv [3];
    logic signed [32:0] r_pa [3];
    logic signed [34:0] r_sep2, r_acc2;
    logic signed [34:0] r_sep3, r_sep4;
    logic signed [35:0] r_accsep3;
    logic signed [45:0] r_nsr3, r_nsr4, r_ra4;
    logic               r_accneg4;
    logic               r_sep_pos3, r_sep_pos4, r_sep_pos5;
    logic [42:0]        r_delta5;

    t_fsd               n_s1;
    logic signed [32:0] n_pv [3];
    logic signed [32:0] n_pa [3];
    logic signed [16:0] w_dv, w_da;
    logic signed [15:0] w_nc;
    logic signed [51:0] w_accp;
    logic signed [46:0] w_sum, w_newsep;
    logic signed [47:0] w_dl;
    logic [58:0]        w_dvd [4];
    logic               w_pen_pos, w_tot_zero;
    pcr_pkg::t_div_bus  n_bus;

    always_comb begin
        n_s1.velocity_a = i_data.velocity_a;
        n_s1.velocity_b = i_data.velocity_b;
        n_s1.normal     = i_data.contact_normal;
        n_s1.two        = i_data.has_second;
        n_s1.ima        = i_data.inv_mass_a;
        n_s1.imb        = i_data.has_second ? i_data.inv_mass_b : 16'd0;
        n_s1.total      = {1'b0, i_data.inv_mass_a}
                        + {1'b0, (i_data.has_second ? i_data.inv_mass_b : 16'd0)};
        n_s1.pen        = i_data.penetration;
        w_dv = '0;
        w_da = '0;
        w_nc = '0;
        for (int i = 0; i < 3; i++) begin
            w_nc = pcr_pkg::comp16(i_data.contact_normal, 2'(i));
            w_dv = 17'(pcr_pkg::comp16(i_data.velocity_a, 2'(i)))
                 - (i_data.has_second ? 17'(pcr_pkg::comp16(i_data.velocity_b, 2'(i)))
                                      : 17'sd0);
            w_da = 17'(pcr_pkg::comp16(i_data.accel_a, 2'(i)))
                 - (i_data.has_second ? 17'(pcr_pkg::comp16(i_data.accel_b, 2'(i)))
                                      : 17'sd0);
            n_pv[i] = 33'(w_dv) * 33'(w_nc);
            n_pa[i] = 33'(w_da) * 33'(w_nc);
        end
    end

    always_comb begin
        w_accp = 52'(r_acc2) * 52'($signed({1'b0, i_time_step}));
        w_sum = 47'(r_nsr4) + 47'(r_ra4);
        if (r_accneg4) begin
            w_newsep = (w_sum < 47'sd0) ? 47'sd0 : w_sum;
        end else begin
            w_newsep = 47'(r_nsr4);
        end
        w_dl = 48'(w_newsep) - (48'(r_sep4) <<< 8);
    end

    always_comb begin
        w_tot_zero = (r_s5.total == 17'd0);
        w_pen_pos  = !r_s5.pen[15] && (r_s5.pen != 16'sd0);
        w_dvd[pcr_pkg::LaneVelA]  = 59'(r_delta5) * 59'(r_s5.ima);
        w_dvd[pcr_pkg::LaneVelB]  = 59'(r_delta5) * 59'(r_s5.imb);
        w_dvd[pcr_pkg::LaneMoveA] = 59'(r_s5.pen[14:0]) * 59'({r_s5.ima, 8'd0});
        w_dvd[pcr_pkg::LaneMoveB] = 59'(r_s5.pen[14:0]) * 59'({r_s5.imb, 8'd0});
        for (int l = 0; l < pcr_pkg::Lanes; l++) begin
            n_bus.lane[l].rem  = {1'b0, w_dvd[l][58:43]};
            n_bus.lane[l].work = w_dvd[l][42:0];
        end
        n_bus.total           = r_s5.total;
        n_bus.side.velocity_a = r_s5.velocity_a;
        n_bus.side.velocity_b = r_s5.velocity_b;
        n_bus.side.normal     = r_s5.normal;
        n_bus.side.two        = r_s5.two;
        n_bus.side.pass_vel   = w_tot_zero || r_sep_pos5;
        n_bus.side.zero_move  = w_tot_zero || !w_pen_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v     <= {r_v[3:0], i_valid};
            o_valid <= r_v[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
            for (int i = 0; i < 3; i++) begin
                r_pv[i] <= n_pv[i];
                r_pa[i] <= n_pa[i];
            end
            r_s2   <= r_s1;
            r_sep2 <= 35'(r_pv[0]) + 35'(r_pv[1]) + 35'(r_pv[2]);
            r_acc2 <= 35'(r_pa[0]) + 35'(r_pa[1]) + 35'(r_pa[2]);
            r_s3       <= r_s2;
            r_sep3     <= r_sep2;
            r_sep_pos3 <= (r_sep2 > 35'sd0);
            r_accsep3  <= 36'(w_accp >>> 16);
            r_nsr3     <= (46'sd0 - 46'(r_sep2)) * 46'($signed({1'b0, i_restitution}));
            r_s4       <= r_s3;
            r_sep4     <= r_sep3;
            r_sep_pos4 <= r_sep_pos3;
            r_nsr4     <= r_nsr3;
            r_accneg4  <= (r_accsep3 < 36'sd0);
            r_ra4      <= 46'(r_accsep3) * 46'($signed({1'b0, i_restitution}));
            r_s5       <= r_s4;
            r_sep_pos5 <= r_sep_pos4;
            r_delta5   <= w_dl[42:0];
            o_bus      <= n_bus;
        end
    end

endmodule

// ----- src/pcr_div_stage.sv -----
module pcr_div_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  pcr_pkg::t_div_bus i_bus,
    output logic              o_valid,
    output pcr_pkg::t_div_bus o_bus
);

    pcr_pkg::t_div_bus n_bus;
    logic [17:0]       w_t;
    logic              w_ge;

    always_comb begin
        n_bus = i_bus;
        w_t   = '0;
        w_ge  = 1'b0;
        for (int l = 0; l < pcr_pkg::Lanes; l++) begin
            w_t  = {i_bus.lane[l].rem, i_bus.lane[l].work[42]};
            w_ge = (w_t >= {1'b0, i_bus.total});
            n_bus.lane[l].rem  = w_ge ? 17'(w_t - {1'b0, i_bus.total}) : w_t[16:0];
            n_bus.lane[l].work = {i_bus.lane[l].work[41:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_bus <= n_bus;
        end
    end

endmodule

// ----- src/pcr_back.sv -----
module pcr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  pcr_pkg::t_div_bus  i_bus,
    output logic               o_valid,
    output pcr_pkg::t_out_item o_data
);

    logic signed [60:0] r_p [4][3];
    pcr_pkg::t_side     r_side;
    logic               r_v;

    logic signed [60:0] n_p [4][3];
    logic signed [60:0] w_s;
    logic signed [44:0] w_x;
    logic [15:0]        w_c [4][3];
    pcr_pkg::t_out_item n_data;

    always_comb begin
        for (int l = 0; l < pcr_pkg::Lanes; l++) begin
            for (int i = 0; i < 3; i++) begin
                n_p[l][i] = 61'(pcr_pkg::comp16(i_bus.side.normal, 2'(i)))
                          * 61'($signed({1'b0, i_bus.lane[l].work}));
            end
        end
    end

    always_comb begin
        w_s = '0;
        w_x = '0;
        for (int i = 0; i < 3; i++) begin
            w_s = r_p[pcr_pkg::LaneVelA][i] >>> 24;
            w_x = 45'(pcr_pkg::comp16(r_side.velocity_a, 2'(i))) + 45'(w_s);
            w_c[pcr_pkg::LaneVelA][i] = pcr_pkg::sat16(w_x);
            w_s = (61'sd0 - r_p[pcr_pkg::LaneVelB][i]) >>> 24;
            w_x = 45'(pcr_pkg::comp16(r_side.velocity_b, 2'(i))) + 45'(w_s);
            w_c[pcr_pkg::LaneVelB][i] = pcr_pkg::sat16(w_x);
            w_s = r_p[pcr_pkg::LaneMoveA][i] >>> 16;
            w_c[pcr_pkg::LaneMoveA][i] = pcr_pkg::sat16(45'(w_s));
            w_s = (61'sd0 - r_p[pcr_pkg::LaneMoveB][i]) >>> 16;
            w_c[pcr_pkg::LaneMoveB][i] = pcr_pkg::sat16(45'(w_s));
        end
        n_data.new_velocity_a = r_side.pass_vel ? r_side.velocity_a
            : {w_c[pcr_pkg::LaneVelA][2], w_c[pcr_pkg::LaneVelA][1],
               w_c[pcr_pkg::LaneVelA][0]};
        n_data.new_velocity_b = (r_side.pass_vel || !r_side.two) ? r_side.velocity_b
            : {w_c[pcr_pkg::LaneVelB][2], w_c[pcr_pkg::LaneVelB][1],
               w_c[pcr_pkg::LaneVelB][0]};
        n_data.move_a = r_side.zero_move ? 48'd0
            : {w_c[pcr_pkg::LaneMoveA][2], w_c[pcr_pkg::LaneMoveA][1],
               w_c[pcr_pkg::LaneMoveA][0]};
        n_data.move_b = (r_side.zero_move || !r_side.two) ? 48'd0
            : {w_c[pcr_pkg::LaneMoveB][2], w_c[pcr_pkg::LaneMoveB][1],
               w_c[pcr_pkg::LaneMoveB][0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v     <= i_valid;
            o_valid <= r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p    <= n_p;
            r_side <= i_bus.side;
            o_data <= n_data;
        end
    end

endmodule

// ----- src/particle_contact_resolver.sv -----
// particle contact resolver: one contact in, one resolved contact out
// input channel: i_valid / o_stall with payload i_data; a transfer happens
// at a rising edge with i_valid high and o_stall low
// output channel: o_valid / i_stall with payload o_data, same rule
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 restitution, 1 time step) at the rising edge; write only while idle
// latency: 51 cycles from input transfer to o_valid (6 front stages for
// dot products, restitution and dividends, 43 restoring divider stages at
// one quotient bit per stage, 2 back stages for scaling and saturation)
// throughput: one contact per cycle, set by the fully pipelined divider
// the whole pipeline holds while the output register is full and i_stall
// is high; o_stall then goes high and nothing is lost or repeated
// reset (synchronous, active low) empties the pipeline and loads
// restitution 0 and time step 1092
module particle_contact_resolver (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  pcr_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output pcr_pkg::t_out_item o_data,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);

    logic [8:0]  r_restitution;
    logic [15:0] r_time_step;
    logic        w_en;

    logic              w_dv  [pcr_pkg::DivSteps+1];
    pcr_pkg::t_div_bus w_div [pcr_pkg::DivSteps+1];

    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restitution <= 9'd0;
            r_time_step   <= 16'd1092;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pcr_pkg::CfgRestitution: r_restitution <= i_cfg_data[8:0];
                pcr_pkg::CfgTimeStep:    r_time_step   <= i_cfg_data;
                default:                 r_time_step   <= r_time_step;
            endcase
        end
    end

    pcr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (i_valid),
        .i_data        (i_data),
        .i_restitution (r_restitution),
        .i_time_step   (r_time_step),
        .o_valid       (w_dv[0]),
        .o_bus         (w_div[0])
    );

    for (genvar g = 0; g < pcr_pkg::DivSteps; g++) begin : g_div
        pcr_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv[g]),
            .i_bus   (w_div[g]),
            .o_valid (w_dv[g+1]),
            .o_bus   (w_div[g+1])
        );
    end

    pcr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dv[pcr_pkg::DivSteps]),
        .i_bus   (w_div[pcr_pkg::DivSteps]),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule
